>>> rtl/core/encoder_driven_pot_spi_writer_defines.svh
// ----------------------------------------------------------------------------
// encoder_driven_pot_spi_writer_defines
// Assertion macros shared by the modules of the pot writer.
// ----------------------------------------------------------------------------
`ifndef ENCODER_DRIVEN_POT_SPI_WRITER_DEFINES_SVH
`define ENCODER_DRIVEN_POT_SPI_WRITER_DEFINES_SVH

// assertion on an explicit clock and active-low reset
`define EDPSW_ASSERT_CLK(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
		else $error("edpsw assertion failed");

// assertion on the block clock and reset
`define EDPSW_ASSERT(lbl, prop) `EDPSW_ASSERT_CLK(lbl, clk, arst_n, prop)

`endif

>>> rtl/core/edpsw_pkg.sv
// ----------------------------------------------------------------------------
// edpsw_pkg
// Types and constants of the encoder driven pot SPI writer.
// ----------------------------------------------------------------------------
package edpsw_pkg;

	// wiper range
	localparam logic [6:0] LEVEL_MAX = 7'd127;

	// frame steps
	localparam logic [5:0] STEP_IDLE       = 6'd0;
	localparam logic [5:0] STEP_SEL_HI     = 6'd1;
	localparam logic [5:0] STEP_SEL_LO     = 6'd2;
	localparam logic [5:0] STEP_ADDR_FIRST = 6'd3;
	localparam logic [5:0] STEP_GAP_ONE    = 6'd19;
	localparam logic [5:0] STEP_DATA_FIRST = 6'd20;
	localparam logic [5:0] STEP_GAP_TWO    = 6'd36;

	// configuration register indexes
	localparam logic [1:0] REG_HALF_PERIOD = 2'd0;
	localparam logic [1:0] REG_GAP         = 2'd1;
	localparam logic [1:0] REG_START_LEVEL = 2'd2;

	// configuration reset values
	localparam logic [7:0] HALF_PERIOD_RST = 8'd1;
	localparam logic [7:0] GAP_RST         = 8'd5;
	localparam logic [7:0] START_LEVEL_RST = 8'd0;

	// queue depth
	localparam int QUEUE_DEPTH = 2;

	// one result beat
	typedef struct packed {
		logic       cs_n;
		logic       sck;
		logic       mosi;
		logic [6:0] wiper_level;
		logic       busy_res;
	} result_t;

	// configuration write
	typedef struct packed {
		logic       we;
		logic [1:0] index;
		logic [7:0] data;
	} cfg_wr_t;

endpackage

>>> rtl/core/edpsw_front.sv
// ----------------------------------------------------------------------------
// edpsw_front
// Tick engine: decodes encoder and load, tracks the level and steps the frame.
// ----------------------------------------------------------------------------
`include "encoder_driven_pot_spi_writer_defines.svh"

module edpsw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_fire,
	input  logic               enc_a,
	input  logic               enc_b,
	input  logic               load_start,
	input  edpsw_pkg::cfg_wr_t cfg,
	output edpsw_pkg::result_t res
);

	logic [7:0] half_q;
	logic [7:0] gap_q;
	logic [7:0] start_level_q;

	logic       last_a_q;
	logic [6:0] level_q;
	logic [5:0] step_q;
	logic [7:0] tick_q;
	logic [7:0] shift_q;

	logic       last_a_n;
	logic [6:0] level_n;
	logic [5:0] step_n;
	logic [7:0] tick_n;
	logic [7:0] shift_n;

	logic       start;
	logic [5:0] cur_step;
	logic [7:0] cur_tick;
	logic [7:0] cur_shift;
	logic       in_addr;
	logic       in_data;
	logic       in_gap;
	logic [7:0] phase_len;
	logic       phase_done;
	logic       sck_c;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q        <= edpsw_pkg::HALF_PERIOD_RST;
			gap_q         <= edpsw_pkg::GAP_RST;
			start_level_q <= edpsw_pkg::START_LEVEL_RST;
		end else if (cfg.we) begin
			unique case (cfg.index)
				edpsw_pkg::REG_HALF_PERIOD: half_q        <= cfg.data;
				edpsw_pkg::REG_GAP:         gap_q         <= cfg.data;
				edpsw_pkg::REG_START_LEVEL: start_level_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// encoder and load decode while idle
	always_comb begin
		level_n  = level_q;
		last_a_n = last_a_q;
		start    = 1'b0;
		if (step_q == edpsw_pkg::STEP_IDLE) begin
			if (load_start) begin
				level_n = (start_level_q > {1'b0, edpsw_pkg::LEVEL_MAX}) ?
					7'd0 : start_level_q[6:0];
				start   = 1'b1;
			end else if (enc_a != last_a_q) begin
				if (enc_b != enc_a) begin
					if (level_q != edpsw_pkg::LEVEL_MAX) level_n = level_q + 7'd1;
				end else begin
					if (level_q != 7'd0) level_n = level_q - 7'd1;
				end
				start = 1'b1;
			end
			last_a_n = enc_a;
		end
	end

	// step of this tick
	assign cur_step  = start ? edpsw_pkg::STEP_SEL_HI : step_q;
	assign cur_tick  = start ? 8'd0 : tick_q;
	assign cur_shift = start ? {1'b0, level_n} : shift_q;

	assign in_addr = (cur_step >= edpsw_pkg::STEP_ADDR_FIRST) &&
		(cur_step < edpsw_pkg::STEP_GAP_ONE);
	assign in_data = (cur_step >= edpsw_pkg::STEP_DATA_FIRST) &&
		(cur_step < edpsw_pkg::STEP_GAP_TWO);
	assign in_gap  = (cur_step == edpsw_pkg::STEP_GAP_ONE) ||
		(cur_step == edpsw_pkg::STEP_GAP_TWO);

	// odd offset into a bit pair is the high half
	assign sck_c = in_addr ? ~cur_step[0] : (in_data ? cur_step[0] : 1'b0);

	// phase length, zero acts as one
	always_comb begin
		phase_len = in_gap ? gap_q : half_q;
		if (phase_len == 8'd0) phase_len = 8'd1;
	end

	assign phase_done = ({1'b0, cur_tick} + 9'd1) >= {1'b0, phase_len};

	// line levels of this tick
	always_comb begin
		res.cs_n        = 1'b1;
		res.sck         = 1'b0;
		res.mosi        = 1'b1;
		res.wiper_level = level_n;
		res.busy_res    = 1'b0;
		if (cur_step != edpsw_pkg::STEP_IDLE) begin
			res.busy_res = 1'b1;
			res.cs_n     = (cur_step == edpsw_pkg::STEP_SEL_HI);
			res.sck      = sck_c;
			if (in_addr) res.mosi = 1'b0;
			else if (in_data) res.mosi = cur_shift[7];
		end
	end

	// frame sequencer next state
	always_comb begin
		step_n  = step_q;
		tick_n  = tick_q;
		shift_n = cur_shift;
		if (cur_step != edpsw_pkg::STEP_IDLE) begin
			if (phase_done) begin
				tick_n = 8'd0;
				if (in_data && sck_c) shift_n = {cur_shift[6:0], 1'b0};
				step_n = (cur_step >= edpsw_pkg::STEP_GAP_TWO) ?
					edpsw_pkg::STEP_IDLE : cur_step + 6'd1;
			end else begin
				step_n = cur_step;
				tick_n = cur_tick + 8'd1;
			end
		end
	end

	// tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= 1'b0;
			level_q  <= 7'd0;
			step_q   <= edpsw_pkg::STEP_IDLE;
			tick_q   <= 8'd0;
			shift_q  <= 8'd0;
		end else if (in_fire) begin
			last_a_q <= last_a_n;
			level_q  <= level_n;
			step_q   <= step_n;
			tick_q   <= tick_n;
			shift_q  <= shift_n;
		end
	end

	// a started frame is still running after its first tick
	`EDPSW_ASSERT(a_start_runs, (in_fire && start) |=> (step_q != edpsw_pkg::STEP_IDLE))
	// encoder history is frozen during a frame
	`EDPSW_ASSERT(a_last_a_held,
		(in_fire && step_q != edpsw_pkg::STEP_IDLE) |=> $stable(last_a_q))
	// the sequencer only moves on an accepted tick
	`EDPSW_ASSERT(a_step_hold, !in_fire |=> ($stable(step_q) && $stable(level_q)))

endmodule

>>> rtl/core/edpsw_queue.sv
// ----------------------------------------------------------------------------
// edpsw_queue
// Two-entry result queue between the tick engine and the output channel.
// ----------------------------------------------------------------------------
`include "encoder_driven_pot_spi_writer_defines.svh"

module edpsw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  edpsw_pkg::result_t push_data,
	output logic               full,
	output logic               head_valid,
	input  logic               head_stall,
	output edpsw_pkg::result_t head_data
);

	localparam int PtrW = $clog2(edpsw_pkg::QUEUE_DEPTH);
	localparam int CntW = $clog2(edpsw_pkg::QUEUE_DEPTH + 1);

	edpsw_pkg::result_t entry_q [edpsw_pkg::QUEUE_DEPTH];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;
	logic               pop;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == CntW'(edpsw_pkg::QUEUE_DEPTH));
	assign pop        = head_valid && !head_stall;
	assign head_data  = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
			if (push && !pop) count_q <= count_q + CntW'(1);
			else if (pop && !push) count_q <= count_q - CntW'(1);
		end
	end

	// no push into a full queue that is not draining
	`EDPSW_ASSERT(a_no_overflow, (full && head_stall) |-> !push)
	// fill count tracks push and pop
	`EDPSW_ASSERT(a_count_up, (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
	`EDPSW_ASSERT(a_count_down, (pop && !push) |=> (count_q == $past(count_q) - CntW'(1)))

endmodule

>>> rtl/core/encoder_driven_pot_spi_writer.sv
// ----------------------------------------------------------------------------
// encoder_driven_pot_spi_writer
// Encoder driven wiper level with a bit-banged SPI write frame per change.
// ----------------------------------------------------------------------------
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   in       | in_valid/in_stall  | enc_a, enc_b, load_start
//   out      | out_valid/out_stall| cs_n, sck, mosi, wiper_level, busy_res
//   cfg      | cfg_we             | cfg_index, cfg_data
//
// One input beat is one tick and is taken every cycle while in_stall is low;
// its result beat is registered into a two-entry queue and offered from there.
// The tick engine updates level and frame step in the cycle the beat is taken.
// in_stall rises only when the queue is full and out_stall holds its head.
// Reset returns the block to idle with level 0 and the register reset values.
// ----------------------------------------------------------------------------
module encoder_driven_pot_spi_writer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       enc_a,
	input  logic       enc_b,
	input  logic       load_start,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       cs_n,
	output logic       sck,
	output logic       mosi,
	output logic [6:0] wiper_level,
	output logic       busy_res,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	edpsw_pkg::cfg_wr_t cfg;
	edpsw_pkg::result_t tick_res;
	edpsw_pkg::result_t head_res;
	logic               q_full;
	logic               in_fire;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// input beat accepted unless the queue cannot take its result
	assign in_stall = q_full && out_stall;
	assign in_fire  = in_valid && !in_stall;

	// tick engine
	edpsw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.enc_a      (enc_a),
		.enc_b      (enc_b),
		.load_start (load_start),
		.cfg        (cfg),
		.res        (tick_res)
	);

	// result queue toward the output channel
	edpsw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (in_fire),
		.push_data  (tick_res),
		.full       (q_full),
		.head_valid (out_valid),
		.head_stall (out_stall),
		.head_data  (head_res)
	);

	assign cs_n        = head_res.cs_n;
	assign sck         = head_res.sck;
	assign mosi        = head_res.mosi;
	assign wiper_level = head_res.wiper_level;
	assign busy_res    = head_res.busy_res;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the encoder driven pot SPI writer. Every input beat
// is one tick. A tick model in the bench predicts the line levels and the
// wiper level that each tick must give. Each output beat is compared field by
// field against the oldest prediction. Directed ticks cover load clamping,
// saturation at both ends, load against encoder, knob turns during a frame,
// zero lengths and an unknown register index. Random quadrature traffic then
// runs with one long output hold-off. The three idling patterns are spread
// over the directed and random parts.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PRESSURE_CYCLES = 300;
	localparam int FRAME_PAD       = 36;
	localparam int SLOW_PAD        = 44;
	localparam int RANDOM_TICKS    = 60;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// clock, reset and block ports
	logic       clk;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_stall;
	logic       enc_a       = 1'b0;
	logic       enc_b       = 1'b0;
	logic       load_start  = 1'b0;
	logic       out_valid;
	logic       out_stall   = 1'b0;
	logic       cs_n;
	logic       sck;
	logic       mosi;
	logic [6:0] wiper_level;
	logic       busy_res;
	logic       cfg_we      = 1'b0;
	logic [1:0] cfg_index   = edpsw_pkg::REG_HALF_PERIOD;
	logic [7:0] cfg_data    = 8'd0;

	encoder_driven_pot_spi_writer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.enc_a       (enc_a),
		.enc_b       (enc_b),
		.load_start  (load_start),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cs_n        (cs_n),
		.sck         (sck),
		.mosi        (mosi),
		.wiper_level (wiper_level),
		.busy_res    (busy_res),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// tick model state and its copy of the registers
	logic       m_last_a = 1'b0;
	logic [6:0] m_level  = 7'd0;
	logic [5:0] m_step   = edpsw_pkg::STEP_IDLE;
	logic [7:0] m_ticks  = 8'd0;
	logic [7:0] m_shift  = 8'd0;
	logic [7:0] m_half   = edpsw_pkg::HALF_PERIOD_RST;
	logic [7:0] m_gap    = edpsw_pkg::GAP_RST;
	logic [7:0] m_start  = edpsw_pkg::START_LEVEL_RST;

	// predicted line levels, oldest first
	edpsw_pkg::result_t expected_beats[$];
	edpsw_pkg::result_t got_beat;
	edpsw_pkg::result_t want_beat;

	// run bookkeeping
	int error_count    = 0;
	int ticks_taken    = 0;
	int idle_ticks     = 0;
	int beats_checked  = 0;
	int frames_started = 0;
	int tx_idle_pct    = 0;
	int rx_idle_pct    = 0;
	bit hold_pending   = 1'b0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	// encoder lines as the stimulus last set them
	logic       enc_a_now = 1'b0;
	logic       enc_b_now = 1'b0;
	logic [1:0] knob_idx  = 2'd0;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// reset, held once at the start
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// length of one frame step, zero counts as one
	function automatic int phase_ticks(input logic [5:0] step);
		int len;
		len = (step == edpsw_pkg::STEP_GAP_ONE || step == edpsw_pkg::STEP_GAP_TWO) ?
			int'(m_gap) : int'(m_half);
		return (len == 0) ? 1 : len;
	endfunction

	// advance the tick model by one tick and return the line levels it shows
	function automatic edpsw_pkg::result_t predict_tick(input logic a, input logic b,
		input logic ld);
		edpsw_pkg::result_t r;
		logic               start;
		logic [5:0]         s;
		logic [5:0]         offs;
		r.cs_n     = 1'b1;
		r.sck      = 1'b0;
		r.mosi     = 1'b1;
		r.busy_res = 1'b0;
		start      = 1'b0;
		// idle: load or an edge on A starts a frame
		if (m_step == edpsw_pkg::STEP_IDLE) begin
			if (ld) begin
				m_level = (m_start > {1'b0, edpsw_pkg::LEVEL_MAX}) ? 7'd0 : m_start[6:0];
				start = 1'b1;
			end else if (a != m_last_a) begin
				if (b != a) begin
					if (m_level < edpsw_pkg::LEVEL_MAX) m_level = m_level + 7'd1;
				end else begin
					if (m_level > 7'd0) m_level = m_level - 7'd1;
				end
				start = 1'b1;
			end
			m_last_a = a;
			if (start) begin
				m_step  = edpsw_pkg::STEP_SEL_HI;
				m_ticks = 8'd0;
				m_shift = {1'b0, m_level};
				frames_started++;
			end
		end
		// frame waveform for the current step
		if (m_step != edpsw_pkg::STEP_IDLE) begin
			s          = m_step;
			r.busy_res = 1'b1;
			r.cs_n     = (s == edpsw_pkg::STEP_SEL_HI);
			if (s >= edpsw_pkg::STEP_ADDR_FIRST && s < edpsw_pkg::STEP_GAP_ONE) begin
				offs   = s - edpsw_pkg::STEP_ADDR_FIRST;
				r.mosi = 1'b0;
				r.sck  = offs[0];
			end else if (s >= edpsw_pkg::STEP_DATA_FIRST && s < edpsw_pkg::STEP_GAP_TWO) begin
				offs   = s - edpsw_pkg::STEP_DATA_FIRST;
				r.mosi = m_shift[7];
				r.sck  = offs[0];
			end
			if (int'(m_ticks) + 1 >= phase_ticks(s)) begin
				m_ticks = 8'd0;
				if (s >= edpsw_pkg::STEP_DATA_FIRST && s < edpsw_pkg::STEP_GAP_TWO && r.sck)
					m_shift = m_shift << 1;
				m_step = (s >= edpsw_pkg::STEP_GAP_TWO) ? edpsw_pkg::STEP_IDLE : s + 6'd1;
			end else begin
				m_ticks = m_ticks + 8'd1;
			end
		end
		r.wiper_level = m_level;
		return r;
	endfunction

	// one line per mismatch
	task automatic report_error(input string msg);
		$display("ERROR beat %0d: %s", beats_checked, msg);
		error_count++;
	endtask

	task automatic compare_field(input string field, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("%s is %0d, expected %0d", field, got, want));
	endtask

	// monitor: check output beats, predict input beats, track register writes
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_beats.size() == 0) begin
					report_error("output beat with no prediction waiting");
				end else begin
					want_beat = expected_beats.pop_front();
					got_beat  = '{cs_n, sck, mosi, wiper_level, busy_res};
					compare_field("cs_n", 32'(got_beat.cs_n), 32'(want_beat.cs_n));
					compare_field("sck", 32'(got_beat.sck), 32'(want_beat.sck));
					compare_field("mosi", 32'(got_beat.mosi), 32'(want_beat.mosi));
					compare_field("wiper_level", 32'(got_beat.wiper_level),
						32'(want_beat.wiper_level));
					compare_field("busy_res", 32'(got_beat.busy_res),
						32'(want_beat.busy_res));
				end
				beats_checked++;
			end
			if (in_valid && !in_stall) begin
				ticks_taken++;
				if (m_step == edpsw_pkg::STEP_IDLE) idle_ticks++;
				expected_beats.push_back(predict_tick(enc_a, enc_b, load_start));
			end
			if (cfg_we) begin
				case (cfg_index)
					edpsw_pkg::REG_HALF_PERIOD: m_half  = cfg_data;
					edpsw_pkg::REG_GAP:         m_gap   = cfg_data;
					edpsw_pkg::REG_START_LEVEL: m_start = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// receiver: random stall, or a long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left    = PRESSURE_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	// watchdog on cycles with no beat moving
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// send one tick, with random idle cycles ahead of it
	task automatic send_tick(input logic a, input logic b, input logic ld);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		enc_a      <= a;
		enc_b      <= b;
		load_start <= ld;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// stop sending and wait for every predicted beat
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0) @(posedge clk);
	endtask

	// register write while nothing is in flight
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// ticks that keep the encoder lines where they are
	task automatic hold_ticks(input int n);
		repeat (n) send_tick(enc_a_now, enc_b_now, 1'b0);
	endtask

	// one detent: toggle A, with B set for the wanted direction
	task automatic turn_knob(input bit up);
		enc_a_now = ~enc_a_now;
		enc_b_now = up ? ~enc_a_now : enc_a_now;
		send_tick(enc_a_now, enc_b_now, 1'b0);
	endtask

	task automatic load_level(input logic [7:0] lvl);
		write_reg(edpsw_pkg::REG_START_LEVEL, lvl);
		send_tick(enc_a_now, enc_b_now, 1'b1);
		hold_ticks(FRAME_PAD);
	endtask

	// idle lines after reset and a first frame at reset timing
	task automatic test_reset_values;
		hold_ticks(2);
		send_tick(enc_a_now, enc_b_now, 1'b1);
		hold_ticks(SLOW_PAD);
	endtask

	// start levels above the top clamp to zero
	task automatic test_load_clamp;
		write_reg(edpsw_pkg::REG_GAP, 8'd1);
		load_level(8'd200);
	endtask

	// turns past either end keep the level and still send a frame
	task automatic test_saturation;
		turn_knob(1'b0);
		hold_ticks(FRAME_PAD);
		load_level(8'd127);
		turn_knob(1'b1);
		hold_ticks(FRAME_PAD);
	endtask

	// a turn during a frame is taken once the frame ends, load is ignored
	task automatic test_turn_during_frame;
		turn_knob(1'b0);
		hold_ticks(10);
		send_tick(enc_a_now, enc_b_now, 1'b1);
		enc_a_now = ~enc_a_now;
		enc_b_now = ~enc_a_now;
		hold_ticks(2 * FRAME_PAD);
	endtask

	// load wins over an edge on A in the same tick, A history still moves
	task automatic test_load_with_encoder;
		enc_a_now = ~enc_a_now;
		enc_b_now = ~enc_a_now;
		write_reg(edpsw_pkg::REG_START_LEVEL, 8'd42);
		send_tick(enc_a_now, enc_b_now, 1'b1);
		hold_ticks(FRAME_PAD);
	endtask

	// zero lengths act as one tick, an unknown index changes nothing
	task automatic test_zero_and_bad_index;
		write_reg(edpsw_pkg::REG_HALF_PERIOD, 8'd0);
		write_reg(edpsw_pkg::REG_GAP, 8'd0);
		write_reg(REG_UNUSED, 8'hFF);
		send_tick(enc_a_now, enc_b_now, 1'b1);
		hold_ticks(FRAME_PAD);
	endtask

	// random quadrature traffic with some noise and loads
	task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int target,
		input bit with_pressure);
		int   goal;
		int   roll;
		bit   pressed;
		bit   reconfigured;
		logic ld;
		logic [1:0] dir;
		pressed      = 1'b0;
		reconfigured = 1'b0;
		dir          = 2'd1;
		tx_idle_pct  = tx_pct;
		rx_idle_pct  = rx_pct;
		write_reg(edpsw_pkg::REG_HALF_PERIOD, 8'($urandom_range(1, 3)));
		write_reg(edpsw_pkg::REG_GAP, 8'($urandom_range(1, 6)));
		write_reg(edpsw_pkg::REG_START_LEVEL, 8'($urandom_range(0, 255)));
		goal = ticks_taken + target;
		while (ticks_taken < goal) begin
			// long output hold-off while ticks keep coming
			if (with_pressure && !pressed && ticks_taken >= goal - target / 2) begin
				hold_pending = 1'b1;
				pressed      = 1'b1;
			end
			// new timing part way through
			if (!reconfigured && ticks_taken >= goal - target / 3) begin
				reconfigured = 1'b1;
				write_reg(edpsw_pkg::REG_HALF_PERIOD, 8'($urandom_range(1, 2)));
				write_reg(edpsw_pkg::REG_START_LEVEL, 8'($urandom_range(0, 255)));
			end
			roll = $urandom_range(99);
			if (roll < 70) begin
				if ($urandom_range(9) == 0) dir = -dir;
				knob_idx  = knob_idx + dir;
				enc_a_now = knob_idx[1] ^ knob_idx[0];
				enc_b_now = knob_idx[1];
			end else if (roll >= 90) begin
				enc_a_now = 1'($urandom_range(1));
				enc_b_now = 1'($urandom_range(1));
			end
			ld = ($urandom_range(99) < 4);
			send_tick(enc_a_now, enc_b_now, ld);
		end
	endtask

	// test sequence
	initial begin
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		tx_idle_pct = 7;
		rx_idle_pct = 87;
		test_reset_values();
		test_load_clamp();
		test_saturation();
		tx_idle_pct = 87;
		rx_idle_pct = 7;
		test_turn_during_frame();
		test_load_with_encoder();
		test_zero_and_bad_index();
		test_random_traffic(0, 0, RANDOM_TICKS, 1'b1);
		write_reg(edpsw_pkg::REG_HALF_PERIOD, edpsw_pkg::HALF_PERIOD_RST);
		write_reg(edpsw_pkg::REG_GAP, edpsw_pkg::GAP_RST);
		send_tick(enc_a_now, enc_b_now, 1'b1);
		hold_ticks(8);
		drain();
		repeat (8) @(posedge clk);
		if (expected_beats.size() != 0)
			report_error($sformatf("%0d predicted beats never came", expected_beats.size()));
		$display("Covered %0d ticks (%0d while idle), %0d SPI frames, %0d beats checked",
			ticks_taken, idle_ticks, frames_started, beats_checked);
		$display("Step lengths of zero to six ticks, three idling patterns, long output hold-off");
		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
